// ===== hdl/moc_pkg.sv =====
// moc_pkg: shared constants, sizes and controller/datapath interface types
// for the matrix orthonormality checker. No dependencies.
package moc_pkg;

   localparam int MAX_SIZE    = 16;
   localparam int CSR_W       = 5;
   localparam int ELEM_W      = 16;
   localparam int SIDE_W      = $clog2(MAX_SIZE + 1);
   localparam int IDX_W       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int ACC_W       = PROD_W + IDX_W + 1;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_W-1:0] SIZE_RESET = CSR_W'(4);

   typedef struct packed {
      logic load;
      logic start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic last_elem;
      logic last_issue;
      logic pipe_busy;
      logic ok;
   } sts_type;

endpackage

// ===== hdl/moc_ram.sv =====
// moc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module moc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/moc_dp.sv =====
// moc_dp: datapath - size register, load counter, element store, row pair
// sequencing and the multiply-accumulate pipeline. Uses moc_pkg and moc_ram.
module moc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [moc_pkg::CSR_W-1:0]       csr_wr_data,
   input  logic signed [moc_pkg::ELEM_W-1:0] elem,
   input  moc_pkg::cmd_type                cmd,
   output moc_pkg::sts_type                sts
);

   logic [moc_pkg::SIDE_W-1:0] n_ff, n_in;
   logic [moc_pkg::CNT_W-1:0]  total_ff, total_in;
   logic [moc_pkg::CNT_W-1:0]  load_cnt_ff, load_cnt_in;

   logic [moc_pkg::IDX_W-1:0]  r_ff, r_in, s_ff, s_in, k_ff, k_in;
   logic [moc_pkg::ADDR_W-1:0] base_r_ff, base_r_in, base_s_ff, base_s_in;
   logic [moc_pkg::IDX_W-1:0]  last_idx;
   logic                       k_end, s_end;

   logic [moc_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [moc_pkg::ELEM_W-1:0] rd_data_a, rd_data_b;

   logic p1_vld_ff, p1_last_ff, p1_diag_ff;
   logic p2_vld_ff, p2_last_ff, p2_diag_ff;
   logic signed [moc_pkg::PROD_W-1:0] prod_ff;
   logic signed [moc_pkg::ACC_W-1:0]  acc_ff, acc_in, sum;
   logic ok_ff, ok_in;

   // size register and load counter
   always_comb begin
      n_in        = n_ff;
      total_in    = total_ff;
      load_cnt_in = load_cnt_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            n_in = moc_pkg::SIDE_W'(1);
         end else if (int'(csr_wr_data) > moc_pkg::MAX_SIZE) begin
            n_in = moc_pkg::SIDE_W'(moc_pkg::MAX_SIZE);
         end else begin
            n_in = moc_pkg::SIDE_W'(csr_wr_data);
         end
         total_in    = moc_pkg::CNT_W'(n_in) * moc_pkg::CNT_W'(n_in);
         load_cnt_in = '0;
      end else if (cmd.load) begin
         load_cnt_in = sts.last_elem ? '0 : load_cnt_ff + moc_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= moc_pkg::SIDE_W'(moc_pkg::SIZE_RESET);
         total_ff    <= moc_pkg::CNT_W'(moc_pkg::SIZE_RESET * moc_pkg::SIZE_RESET);
         load_cnt_ff <= '0;
      end else begin
         n_ff        <= n_in;
         total_ff    <= total_in;
         load_cnt_ff <= load_cnt_in;
      end
   end

   // row pair and element sequencing
   assign last_idx = moc_pkg::IDX_W'(n_ff - moc_pkg::SIDE_W'(1));
   assign k_end    = (k_ff == last_idx);
   assign s_end    = (s_ff == last_idx);

   always_comb begin
      r_in      = r_ff;
      s_in      = s_ff;
      k_in      = k_ff;
      base_r_in = base_r_ff;
      base_s_in = base_s_ff;
      if (cmd.start) begin
         r_in      = '0;
         s_in      = '0;
         k_in      = '0;
         base_r_in = '0;
         base_s_in = '0;
      end else if (cmd.step) begin
         if (!k_end) begin
            k_in = k_ff + moc_pkg::IDX_W'(1);
         end else begin
            k_in = '0;
            if (!s_end) begin
               s_in      = s_ff + moc_pkg::IDX_W'(1);
               base_s_in = base_s_ff + moc_pkg::ADDR_W'(n_ff);
            end else begin
               r_in      = r_ff + moc_pkg::IDX_W'(1);
               s_in      = r_ff + moc_pkg::IDX_W'(1);
               base_r_in = base_r_ff + moc_pkg::ADDR_W'(n_ff);
               base_s_in = base_r_ff + moc_pkg::ADDR_W'(n_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      s_ff      <= s_in;
      k_ff      <= k_in;
      base_r_ff <= base_r_in;
      base_s_ff <= base_s_in;
   end

   assign rd_addr_a = base_r_ff + moc_pkg::ADDR_W'(k_ff);
   assign rd_addr_b = base_s_ff + moc_pkg::ADDR_W'(k_ff);

   // two copies of the store give two reads per cycle
   moc_ram #(
      .WIDTH (moc_pkg::ELEM_W),
      .DEPTH (moc_pkg::STORE_DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (load_cnt_ff[moc_pkg::ADDR_W-1:0]),
      .wr_data (elem),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   moc_ram #(
      .WIDTH (moc_pkg::ELEM_W),
      .DEPTH (moc_pkg::STORE_DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (load_cnt_ff[moc_pkg::ADDR_W-1:0]),
      .wr_data (elem),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // multiply-accumulate pipeline
   assign sum = acc_ff + moc_pkg::ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      ok_in  = ok_ff;
      if (cmd.start) begin
         acc_in = '0;
         ok_in  = 1'b1;
      end else if (p2_vld_ff) begin
         if (p2_last_ff) begin
            acc_in = '0;
            if (sum != (p2_diag_ff ? moc_pkg::ACC_W'(1) : moc_pkg::ACC_W'(0))) begin
               ok_in = 1'b0;
            end
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         ok_ff     <= 1'b1;
      end else begin
         p1_vld_ff <= cmd.step;
         p2_vld_ff <= p1_vld_ff;
         ok_ff     <= ok_in;
      end
      p1_last_ff <= k_end;
      p1_diag_ff <= (r_ff == s_ff);
      p2_last_ff <= p1_last_ff;
      p2_diag_ff <= p1_diag_ff;
      prod_ff    <= $signed(rd_data_a) * $signed(rd_data_b);
      acc_ff     <= acc_in;
   end

   assign sts.last_elem  = ((load_cnt_ff + moc_pkg::CNT_W'(1)) >= total_ff);
   assign sts.last_issue = k_end && s_end && (r_ff == last_idx);
   assign sts.pipe_busy  = p1_vld_ff || p2_vld_ff;
   assign sts.ok         = ok_ff;

endmodule

// ===== hdl/moc_ctrl.sv =====
// moc_ctrl: controller - load, sweep and drain sequencing plus the result
// beat register. Uses moc_pkg.
module moc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_bit,
   output moc_pkg::cmd_type cmd,
   input  moc_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      rsp_bit_ff, rsp_bit_in;
   logic      accept;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_bit_in    = rsp_bit_ff;
      cmd           = '0;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = accept;
            if (accept && sts.last_elem) begin
               cmd.start = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy && (!rsp_tvalid_ff || rsp_tready)) begin
               rsp_tvalid_in = 1'b1;
               rsp_bit_in    = sts.ok;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_bit    = rsp_bit_ff;

endmodule

// ===== hdl/matrix_orthonormality_check.sv =====
// matrix_orthonormality_check: loads an n-by-n matrix, one beat per cycle, then one
// multiply-accumulate per cycle over every row pair with s >= r.
// one matrix at a time through the single mac unit: loading resumes only once the result beat is issued
// reset: synchronous, clears control, size back to 4, store left unwritten
// uses moc_pkg, moc_ctrl, moc_dp
module matrix_orthonormality_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [moc_pkg::CSR_W-1:0]       csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [moc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [15:0] elem_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [moc_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [0] is_orthonormal
);

   moc_pkg::cmd_type cmd;
   moc_pkg::sts_type sts;
   logic             rsp_bit;

   moc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_bit    (rsp_bit),
      .cmd        (cmd),
      .sts        (sts)
   );

   moc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .elem        ($signed(req_tdata[moc_pkg::ELEM_W-1:0])),
      .cmd         (cmd),
      .sts         (sts)
   );

   assign rsp_tdata = {{(moc_pkg::RSP_DATA_W-1){1'b0}}, rsp_bit};

endmodule

// ===== hdl/moc_checker.sv =====
// moc_checker: port-level assertions for matrix_orthonormality_check, bound to
// the top level. Uses moc_pkg.
module moc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [moc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[moc_pkg::RSP_DATA_W-1:1] == '0)
      else $error("result padding not zero");

   // loading only stops on an accepted element beat
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid && req_tready))
      else $error("ready dropped without an accepted beat");

   // a new result only appears once loading has resumed
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while not loading");

endmodule

bind matrix_orthonormality_check moc_checker u_moc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
